// ===== sv/ldpc_segment_and_lift_select_defines.svh =====
// Assertion macros shared by the block's RTL.
`ifndef LDPC_SEGMENT_AND_LIFT_SELECT_DEFINES_SVH
`define LDPC_SEGMENT_AND_LIFT_SELECT_DEFINES_SVH

`ifndef SYNTHESIS

// Implication checked at every rising edge outside reset.
`define SLS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("segmentation and lifting check failed");

// Plain condition checked at every rising edge outside reset.
`define SLS_ASSERT_ALWAYS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("segmentation and lifting check failed");

`else

`define SLS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define SLS_ASSERT_ALWAYS(lbl, ck, rn, cond)

`endif

`endif

// ===== sv/ldpc_sls_pkg.sv =====
package ldpc_sls_pkg;

  // Field widths.
  localparam int unsigned BLK_W   = 21;
  localparam int unsigned RATE_W  = 11;
  localparam int unsigned KBITS_W = 14;
  localparam int unsigned KB_W    = 5;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CRC_W   = 5;
  localparam int unsigned SET_W   = 4;
  localparam int unsigned GRAPH_W = 2;
  localparam int unsigned ZC_W    = 9;
  localparam int unsigned NBITS_W = 15;
  localparam int unsigned ROWS_W  = 6;
  localparam int unsigned COLS_W  = 7;

  // Segmentation.
  localparam logic [BLK_W-1:0]  B_MAX   = 21'd1310720;
  localparam logic [BLK_W-1:0]  CB_MAX  = 21'd8448;
  localparam logic [CRC_W-1:0]  SEG_CRC = 5'd24;
  localparam int unsigned       SEG_LEN = 8448 - 24;

  // Block count by reciprocal: floor(x * SEG_RECIP / 2^RECIP_SHIFT) is the true
  // quotient or one less for any 21-bit x.
  localparam int unsigned       RECIP_SHIFT = 34;
  localparam int unsigned       PROD_W      = BLK_W + BLK_W;
  localparam logic [BLK_W-1:0]  SEG_RECIP   = BLK_W'((64'd1 << RECIP_SHIFT) / SEG_LEN);

  // One restoring step per quotient bit of the block size over block count.
  localparam int unsigned DIV_STEPS = KBITS_W;

  // Graph selection.
  localparam logic [RATE_W-1:0] RATE_THR   = 11'd686;
  localparam logic [BLK_W-1:0]  KB_THR_A   = 21'd640;
  localparam logic [BLK_W-1:0]  KB_THR_B   = 21'd560;
  localparam logic [BLK_W-1:0]  KB_THR_C   = 21'd192;
  localparam logic [KB_W-1:0]   KB_G1      = 5'd22;
  localparam logic [KB_W-1:0]   KB_G2_A    = 5'd10;
  localparam logic [KB_W-1:0]   KB_G2_B    = 5'd9;
  localparam logic [KB_W-1:0]   KB_G2_C    = 5'd8;
  localparam logic [KB_W-1:0]   KB_G2_D    = 5'd6;

  localparam logic [GRAPH_W-1:0] GRAPH_1 = 2'd1;
  localparam logic [GRAPH_W-1:0] GRAPH_2 = 2'd2;

  localparam logic [KBITS_W-1:0] K_MUL_G1 = 14'd22;
  localparam logic [KBITS_W-1:0] K_MUL_G2 = 14'd10;
  localparam logic [NBITS_W-1:0] N_MUL_G1 = 15'd66;
  localparam logic [NBITS_W-1:0] N_MUL_G2 = 15'd50;
  localparam logic [ROWS_W-1:0]  ROWS_G1  = 6'd46;
  localparam logic [ROWS_W-1:0]  ROWS_G2  = 6'd42;
  localparam logic [COLS_W-1:0]  COLS_G1  = 7'd68;
  localparam logic [COLS_W-1:0]  COLS_G2  = 7'd52;

  // Lifting sizes in ascending order with their set numbers.
  localparam int unsigned LIFT_N = 51;

  localparam logic [ZC_W-1:0] LIFT_Z [LIFT_N] = '{
    9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,
    9'd10,  9'd11,  9'd12,  9'd13,  9'd14,  9'd15,  9'd16,  9'd18,
    9'd20,  9'd22,  9'd24,  9'd26,  9'd28,  9'd30,  9'd32,  9'd36,
    9'd40,  9'd44,  9'd48,  9'd52,  9'd56,  9'd60,  9'd64,  9'd72,
    9'd80,  9'd88,  9'd96,  9'd104, 9'd112, 9'd120, 9'd128, 9'd144,
    9'd160, 9'd176, 9'd192, 9'd208, 9'd224, 9'd240, 9'd256, 9'd288,
    9'd320, 9'd352, 9'd384
  };

  localparam logic [SET_W-1:0] LIFT_SET [LIFT_N] = '{
    4'd1, 4'd2, 4'd1, 4'd3, 4'd2, 4'd4, 4'd1, 4'd5,
    4'd3, 4'd6, 4'd2, 4'd7, 4'd4, 4'd8, 4'd1, 4'd5,
    4'd3, 4'd6, 4'd2, 4'd7, 4'd4, 4'd8, 4'd1, 4'd5,
    4'd3, 4'd6, 4'd2, 4'd7, 4'd4, 4'd8, 4'd1, 4'd5,
    4'd3, 4'd6, 4'd2, 4'd7, 4'd4, 4'd8, 4'd1, 4'd5,
    4'd3, 4'd6, 4'd2, 4'd7, 4'd4, 4'd8, 4'd1, 4'd5,
    4'd3, 4'd6, 4'd2
  };

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  cnt;
    logic              crc_on;
  } seg_info_t;

  typedef struct packed {
    seg_info_t          info;
    logic [KBITS_W-1:0] quot;
    logic               rem_nz;
  } div_res_t;

  typedef struct packed {
    logic [KBITS_W-1:0] info_bits;
    logic [KB_W-1:0]    info_columns;
    logic [KBITS_W-1:0] upper_block_bits;
    logic [KBITS_W-1:0] lower_block_bits;
    logic [CNT_W-1:0]   block_count;
    logic [CRC_W-1:0]   crc_bits;
    logic [SET_W-1:0]   set_index;
    logic [GRAPH_W-1:0] graph_select;
    logic [ZC_W-1:0]    lift_size;
    logic [NBITS_W-1:0] code_bits;
    logic [ROWS_W-1:0]  graph_rows;
    logic [COLS_W-1:0]  graph_cols;
  } lift_res_t;

endpackage

// ===== sv/ldpc_segment_and_lift_select.sv =====
// LDPC code block segmentation and lifting size selection. Each request carries
// a transport block size (CRC included) and a code rate with ten fraction bits;
// each produces exactly one result: block count, per block CRC length, upper and
// lower block sizes, base graph, lifting size with its set number, and the
// lifted information and code lengths. The block takes one request in every
// clock cycle and busy is always low. The result appears on the out_ ports with
// out_valid high for exactly one cycle, in request order, after passing through
// 21 register stages, the first of which loads on the accepting edge: three for
// clamping and the block count, fourteen for the bit-per-stage division of the
// block size by the block count, and four for the lifting size search. The
// receiver cannot stall the block, so it must take every result in the cycle it
// is shown.
`include "ldpc_segment_and_lift_select_defines.svh"

module ldpc_segment_and_lift_select (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [ldpc_sls_pkg::BLK_W-1:0]     in_block_bits,
  input  logic [ldpc_sls_pkg::RATE_W-1:0]    in_code_rate_q10,
  output logic                               out_valid,
  output logic [ldpc_sls_pkg::KBITS_W-1:0]   out_info_bits,
  output logic [ldpc_sls_pkg::KB_W-1:0]      out_info_columns,
  output logic [ldpc_sls_pkg::KBITS_W-1:0]   out_upper_block_bits,
  output logic [ldpc_sls_pkg::KBITS_W-1:0]   out_lower_block_bits,
  output logic [ldpc_sls_pkg::CNT_W-1:0]     out_block_count,
  output logic [ldpc_sls_pkg::CRC_W-1:0]     out_crc_bits,
  output logic [ldpc_sls_pkg::SET_W-1:0]     out_set_index,
  output logic [ldpc_sls_pkg::GRAPH_W-1:0]   out_graph_select,
  output logic [ldpc_sls_pkg::ZC_W-1:0]      out_lift_size,
  output logic [ldpc_sls_pkg::NBITS_W-1:0]   out_code_bits,
  output logic [ldpc_sls_pkg::ROWS_W-1:0]    out_graph_rows,
  output logic [ldpc_sls_pkg::COLS_W-1:0]    out_graph_cols
);
  import ldpc_sls_pkg::*;

  logic      req_take;
  logic      seg_vld;
  seg_info_t seg_info;
  logic      div_vld;
  div_res_t  div_res;
  lift_res_t lift_res;

  // Every stage advances on every clock, so a new request is always welcome.
  assign busy     = 1'b0;
  assign req_take = start && !busy;

  // Clamp the block size and work out the block count and CRC length.
  ldpc_sls_seg u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (req_take),
    .blk_in   (in_block_bits),
    .rate_in  (in_code_rate_q10),
    .out_vld  (seg_vld),
    .info_out (seg_info)
  );

  // Divide the clamped block size by the block count; the quotient and whether
  // a remainder is left give both block sizes.
  ldpc_sls_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (seg_vld),
    .info_in (seg_info),
    .out_vld (div_vld),
    .res_out (div_res)
  );

  // Pick the base graph and the smallest lifting size that covers the upper
  // block size, falling back to graph 1 when graph 2 has none.
  ldpc_sls_lift u_lift (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (div_vld),
    .res_in  (div_res),
    .out_vld (out_valid),
    .res_out (lift_res)
  );

  assign out_info_bits        = lift_res.info_bits;
  assign out_info_columns     = lift_res.info_columns;
  assign out_upper_block_bits = lift_res.upper_block_bits;
  assign out_lower_block_bits = lift_res.lower_block_bits;
  assign out_block_count      = lift_res.block_count;
  assign out_crc_bits         = lift_res.crc_bits;
  assign out_set_index        = lift_res.set_index;
  assign out_graph_select     = lift_res.graph_select;
  assign out_lift_size        = lift_res.lift_size;
  assign out_code_bits        = lift_res.code_bits;
  assign out_graph_rows       = lift_res.graph_rows;
  assign out_graph_cols       = lift_res.graph_cols;

  // Code length and information length come from the same lifting size, so
  // their ratio is fixed by the graph.
  `SLS_ASSERT_IMPL(a_code_ratio, clk, rst_n, out_valid,
    (out_graph_select == GRAPH_1) ?
      (24'(out_code_bits) * 24'(K_MUL_G1) == 24'(out_info_bits) * 24'(N_MUL_G1)) :
      (24'(out_code_bits) * 24'(K_MUL_G2) == 24'(out_info_bits) * 24'(N_MUL_G2)))

  // Upper and lower block sizes differ by at most one.
  `SLS_ASSERT_ALWAYS(a_block_spread, clk, rst_n,
    !out_valid || (out_upper_block_bits == out_lower_block_bits) ||
    (out_upper_block_bits == out_lower_block_bits + 14'd1))

  // A single block carries no extra CRC and is never split unevenly.
  `SLS_ASSERT_IMPL(a_single_block, clk, rst_n, out_valid && (out_block_count == 8'd1),
    (out_crc_bits == '0) && (out_upper_block_bits == out_lower_block_bits))

  // The chosen lifting size covers the upper block size.
  `SLS_ASSERT_IMPL(a_lift_covers, clk, rst_n, out_valid,
    16'(out_lift_size) * 16'(out_info_columns) >= 16'(out_upper_block_bits))

endmodule

// ===== sv/ldpc_sls_seg.sv =====
module ldpc_sls_seg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [ldpc_sls_pkg::BLK_W-1:0]   blk_in,
  input  logic [ldpc_sls_pkg::RATE_W-1:0]  rate_in,
  output logic                             out_vld,
  output ldpc_sls_pkg::seg_info_t          info_out
);
  import ldpc_sls_pkg::*;

  // Stage 1: clamp.
  logic              s1_vld_r;
  logic [BLK_W-1:0]  s1_blk_r, s1_blk_nxt;
  logic [BLK_W-1:0]  s1_x_r, s1_x_nxt;
  logic [RATE_W-1:0] s1_rate_r;
  logic              s1_big_r, s1_big_nxt;

  // Stage 2: reciprocal product.
  logic              s2_vld_r;
  logic [BLK_W-1:0]  s2_blk_r;
  logic [BLK_W-1:0]  s2_x_r;
  logic [RATE_W-1:0] s2_rate_r;
  logic              s2_big_r;
  logic [PROD_W-1:0] s2_prod_r, s2_prod_nxt;

  // Stage 3: corrected block count.
  logic              s3_vld_r;
  seg_info_t         s3_info_r, s3_info_nxt;

  logic [CNT_W-1:0]  q_est;
  logic [BLK_W-1:0]  est_mul;
  logic [BLK_W-1:0]  est_rem;
  logic              est_low;

  always_comb begin
    if (blk_in > B_MAX) begin
      s1_blk_nxt = B_MAX;
    end else if (blk_in == '0) begin
      s1_blk_nxt = BLK_W'(1);
    end else begin
      s1_blk_nxt = blk_in;
    end
    s1_x_nxt   = s1_blk_nxt - BLK_W'(1);
    s1_big_nxt = s1_blk_nxt > CB_MAX;
  end

  assign s2_prod_nxt = PROD_W'(s1_x_r) * PROD_W'(SEG_RECIP);

  always_comb begin
    q_est   = s2_prod_r[RECIP_SHIFT +: CNT_W];
    est_mul = BLK_W'(q_est) * BLK_W'(SEG_LEN);
    est_rem = s2_x_r - est_mul;
    est_low = est_rem >= BLK_W'(SEG_LEN);
    s3_info_nxt.blk    = s2_blk_r;
    s3_info_nxt.rate   = s2_rate_r;
    s3_info_nxt.crc_on = s2_big_r;
    if (s2_big_r) begin
      s3_info_nxt.cnt = q_est + CNT_W'(1) + CNT_W'(est_low);
    end else begin
      s3_info_nxt.cnt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_blk_r  <= s1_blk_nxt;
    s1_x_r    <= s1_x_nxt;
    s1_rate_r <= rate_in;
    s1_big_r  <= s1_big_nxt;
    s2_blk_r  <= s1_blk_r;
    s2_x_r    <= s1_x_r;
    s2_rate_r <= s1_rate_r;
    s2_big_r  <= s1_big_r;
    s2_prod_r <= s2_prod_nxt;
    s3_info_r <= s3_info_nxt;
  end

  assign out_vld  = s3_vld_r;
  assign info_out = s3_info_r;

endmodule

// ===== sv/ldpc_sls_div.sv =====
module ldpc_sls_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  ldpc_sls_pkg::seg_info_t  info_in,
  output logic                     out_vld,
  output ldpc_sls_pkg::div_res_t   res_out
);
  import ldpc_sls_pkg::*;

  // One restoring step per stage, most significant quotient bit first.
  logic               vld_r  [DIV_STEPS];
  logic [BLK_W-1:0]   rem_r  [DIV_STEPS];
  logic [KBITS_W-1:0] quot_r [DIV_STEPS];
  seg_info_t          info_r [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic               vld_in;
    logic [BLK_W-1:0]   rem_in;
    logic [KBITS_W-1:0] quot_in;
    seg_info_t          info_s;
    logic [BLK_W-1:0]   dsh;
    logic               take;
    logic [BLK_W-1:0]   rem_nxt;
    logic [KBITS_W-1:0] quot_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = info_in.blk;
      assign quot_in = '0;
      assign info_s  = info_in;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign quot_in = quot_r[s-1];
      assign info_s  = info_r[s-1];
    end

    always_comb begin
      dsh      = BLK_W'(info_s.cnt) << (DIV_STEPS - 1 - s);
      take     = rem_in >= dsh;
      rem_nxt  = take ? (rem_in - dsh) : rem_in;
      quot_nxt = quot_in;
      quot_nxt[DIV_STEPS-1-s] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      quot_r[s] <= quot_nxt;
      info_r[s] <= info_s;
    end
  end

  assign out_vld        = vld_r[DIV_STEPS-1];
  assign res_out.info   = info_r[DIV_STEPS-1];
  assign res_out.quot   = quot_r[DIV_STEPS-1];
  assign res_out.rem_nz = |rem_r[DIV_STEPS-1];

endmodule

// ===== sv/ldpc_sls_lift.sv =====
module ldpc_sls_lift (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  ldpc_sls_pkg::div_res_t   res_in,
  output logic                     out_vld,
  output ldpc_sls_pkg::lift_res_t  res_out
);
  import ldpc_sls_pkg::*;

  // Stage 0: block sizes, graph 2 column count, rate decision.
  logic               l0_vld_r;
  logic [KBITS_W-1:0] l0_kp_r, l0_kp_nxt;
  logic [KBITS_W-1:0] l0_kn_r, l0_kn_nxt;
  logic [CNT_W-1:0]   l0_cnt_r;
  logic               l0_crc_on_r;
  logic [KB_W-1:0]    l0_kb2_r, l0_kb2_nxt;
  logic               l0_g1_r;

  // Stage 1: coverage of every lifting size for both graphs.
  logic               l1_vld_r;
  logic [KBITS_W-1:0] l1_kp_r, l1_kn_r;
  logic [CNT_W-1:0]   l1_cnt_r;
  logic               l1_crc_on_r;
  logic [KB_W-1:0]    l1_kb2_r;
  logic               l1_g1_r;
  logic [LIFT_N-1:0]  l1_pass1_r, l1_pass1_nxt;
  logic [LIFT_N-1:0]  l1_pass2_r, l1_pass2_nxt;

  // Stage 2: smallest covering size as a one-hot select.
  logic               l2_vld_r;
  logic [KBITS_W-1:0] l2_kp_r, l2_kn_r;
  logic [CNT_W-1:0]   l2_cnt_r;
  logic               l2_crc_on_r;
  logic [KB_W-1:0]    l2_kb_r, l2_kb_nxt;
  logic               l2_g1_r, l2_g1_nxt;
  logic [LIFT_N-1:0]  l2_sel_r, l2_sel_nxt;

  // Stage 3: result register.
  logic               out_vld_r;
  lift_res_t          res_r, res_nxt;

  logic [KBITS_W-1:0] kn_sum;
  logic [KBITS_W-1:0] zkb2;
  logic [LIFT_N-1:0]  oh1, oh2;
  logic [ZC_W-1:0]    zc;
  logic [SET_W-1:0]   set_idx;

  always_comb begin
    kn_sum    = res_in.quot + (res_in.info.crc_on ? KBITS_W'(SEG_CRC) : '0);
    l0_kn_nxt = kn_sum;
    l0_kp_nxt = kn_sum + KBITS_W'(res_in.rem_nz);
    if (res_in.info.blk > KB_THR_A) begin
      l0_kb2_nxt = KB_G2_A;
    end else if (res_in.info.blk > KB_THR_B) begin
      l0_kb2_nxt = KB_G2_B;
    end else if (res_in.info.blk > KB_THR_C) begin
      l0_kb2_nxt = KB_G2_C;
    end else begin
      l0_kb2_nxt = KB_G2_D;
    end
  end

  always_comb begin
    zkb2 = '0;
    for (int i = 0; i < LIFT_N; i++) begin
      l1_pass1_nxt[i] = (KBITS_W'(LIFT_Z[i]) * KBITS_W'(KB_G1)) >= l0_kp_r;
      case (l0_kb2_r)
        KB_G2_A: zkb2 = KBITS_W'(LIFT_Z[i]) * KBITS_W'(KB_G2_A);
        KB_G2_B: zkb2 = KBITS_W'(LIFT_Z[i]) * KBITS_W'(KB_G2_B);
        KB_G2_C: zkb2 = KBITS_W'(LIFT_Z[i]) * KBITS_W'(KB_G2_C);
        default: zkb2 = KBITS_W'(LIFT_Z[i]) * KBITS_W'(KB_G2_D);
      endcase
      l1_pass2_nxt[i] = zkb2 >= l0_kp_r;
    end
  end

  // The sizes ascend, so each coverage vector is a thermometer code and its
  // lowest set bit marks the smallest size that fits.
  always_comb begin
    oh1 = l1_pass1_r & ~{l1_pass1_r[LIFT_N-2:0], 1'b0};
    oh2 = l1_pass2_r & ~{l1_pass2_r[LIFT_N-2:0], 1'b0};
    l2_g1_nxt  = l1_g1_r || !l1_pass2_r[LIFT_N-1];
    l2_sel_nxt = l2_g1_nxt ? oh1 : oh2;
    l2_kb_nxt  = l2_g1_nxt ? KB_G1 : l1_kb2_r;
  end

  always_comb begin
    zc      = '0;
    set_idx = '0;
    for (int i = 0; i < LIFT_N; i++) begin
      zc      = zc | (l2_sel_r[i] ? LIFT_Z[i] : '0);
      set_idx = set_idx | (l2_sel_r[i] ? LIFT_SET[i] : '0);
    end
    res_nxt.info_columns     = l2_kb_r;
    res_nxt.upper_block_bits = l2_kp_r;
    res_nxt.lower_block_bits = l2_kn_r;
    res_nxt.block_count      = l2_cnt_r;
    res_nxt.crc_bits         = l2_crc_on_r ? SEG_CRC : '0;
    res_nxt.set_index        = set_idx;
    res_nxt.lift_size        = zc;
    if (l2_g1_r) begin
      res_nxt.graph_select = GRAPH_1;
      res_nxt.info_bits    = KBITS_W'(zc) * K_MUL_G1;
      res_nxt.code_bits    = NBITS_W'(zc) * N_MUL_G1;
      res_nxt.graph_rows   = ROWS_G1;
      res_nxt.graph_cols   = COLS_G1;
    end else begin
      res_nxt.graph_select = GRAPH_2;
      res_nxt.info_bits    = KBITS_W'(zc) * K_MUL_G2;
      res_nxt.code_bits    = NBITS_W'(zc) * N_MUL_G2;
      res_nxt.graph_rows   = ROWS_G2;
      res_nxt.graph_cols   = COLS_G2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_vld_r  <= 1'b0;
      l1_vld_r  <= 1'b0;
      l2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      l0_vld_r  <= in_vld;
      l1_vld_r  <= l0_vld_r;
      l2_vld_r  <= l1_vld_r;
      out_vld_r <= l2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    l0_kp_r     <= l0_kp_nxt;
    l0_kn_r     <= l0_kn_nxt;
    l0_cnt_r    <= res_in.info.cnt;
    l0_crc_on_r <= res_in.info.crc_on;
    l0_kb2_r    <= l0_kb2_nxt;
    l0_g1_r     <= res_in.info.rate > RATE_THR;

    l1_kp_r     <= l0_kp_r;
    l1_kn_r     <= l0_kn_r;
    l1_cnt_r    <= l0_cnt_r;
    l1_crc_on_r <= l0_crc_on_r;
    l1_kb2_r    <= l0_kb2_r;
    l1_g1_r     <= l0_g1_r;
    l1_pass1_r  <= l1_pass1_nxt;
    l1_pass2_r  <= l1_pass2_nxt;

    l2_kp_r     <= l1_kp_r;
    l2_kn_r     <= l1_kn_r;
    l2_cnt_r    <= l1_cnt_r;
    l2_crc_on_r <= l1_crc_on_r;
    l2_kb_r     <= l2_kb_nxt;
    l2_g1_r     <= l2_g1_nxt;
    l2_sel_r    <= l2_sel_nxt;

    res_r       <= res_nxt;
  end

  assign out_vld = out_vld_r;
  assign res_out = res_r;

endmodule
